// ===== rtl/adm_pkg.sv =====
// shared constants, types and register codes for the adam parameter update block
`default_nettype none
package adm_pkg;

    localparam int NUM_PARAMS = 1024;
    localparam int FRAC_BITS  = 24;
    localparam int ADDR_W     = $clog2(NUM_PARAMS);
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 32;
    localparam int VSQ_W      = 40;
    localparam int POW_W      = 33;
    localparam int ROW_W      = 1 + VSQ_W + DATA_W;
    // root operand width, root width, step quotient width, denominator width
    localparam int X_W        = VSQ_W + 96 - FRAC_BITS;
    localparam int R_W        = X_W / 2;
    localparam int Q_W        = 96;
    localparam int DEN_W      = 90;
    localparam int CNT_W      = $clog2(X_W + 1);

    localparam logic [1:0] CFG_LEARNING_RATE  = 2'd0;
    localparam logic [1:0] CFG_FIRST_DECAY    = 2'd1;
    localparam logic [1:0] CFG_SECOND_DECAY   = 2'd2;
    localparam logic [1:0] CFG_STABILITY_TERM = 2'd3;

    localparam logic [1:0] MARK_CONTINUE  = 2'd0;
    localparam logic [1:0] MARK_ITERATION = 2'd1;
    localparam logic [1:0] MARK_FRESH_RUN = 2'd2;

    localparam logic [CFG_W-1:0] RST_LEARNING_RATE  = 32'd429497;
    localparam logic [CFG_W-1:0] RST_FIRST_DECAY    = 32'd3865470566;
    localparam logic [CFG_W-1:0] RST_SECOND_DECAY   = 32'd4290672329;
    localparam logic [CFG_W-1:0] RST_STABILITY_TERM = 32'd43;

    typedef struct packed {
        logic [CFG_W-1:0] learning_rate;
        logic [CFG_W-1:0] first_decay;
        logic [CFG_W-1:0] second_decay;
        logic [CFG_W-1:0] stability_term;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] grad;
        logic signed [DATA_W-1:0] value;
        logic [POW_W-1:0]         d1;
        logic [POW_W-1:0]         d2;
        logic                     gen;
        logic                     in_range;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/adm_if.sv =====
// item channels for parameter requests and updated values
`default_nettype none
interface adm_in_if;
    logic        valid;
    logic        ready;
    logic [9:0]  element_index;
    logic signed [31:0] gradient_value;
    logic signed [31:0] current_value;
    logic [1:0]  pass_mark;

    modport source (output valid, element_index, gradient_value, current_value, pass_mark,
                    input ready);
    modport sink (input valid, element_index, gradient_value, current_value, pass_mark,
                  output ready);
endinterface

interface adm_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  updated_index;
    logic signed [31:0] updated_value;

    modport source (output valid, updated_index, updated_value, input ready);
    modport sink (input valid, updated_index, updated_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/adm_front.sv =====
// front end: takes items, applies pass marks to the decay powers, builds jobs
`default_nettype none
module adm_front
    import adm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    adm_in_if.sink     item_in,
    input  wire cfg_t  cfg,
    input  wire logic  clear_done,
    input  wire logic  q_full,
    output logic       push,
    output job_t       push_job
);

    logic [POW_W-1:0] p1_reg, p1_next;
    logic [POW_W-1:0] p2_reg, p2_next;
    logic             gen_reg, gen_next;
    logic [POW_W+CFG_W-1:0] p1_prod, p2_prod;

    assign item_in.ready = clear_done && !q_full;
    assign push          = item_in.valid && item_in.ready;

    always_comb
    begin
        p1_prod  = p1_reg * cfg.first_decay + (65'd1 << 31);
        p2_prod  = p2_reg * cfg.second_decay + (65'd1 << 31);
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        gen_next = gen_reg;
        unique case (item_in.pass_mark)
            MARK_ITERATION:
            begin
                p1_next = p1_prod[POW_W+31:32];
                p2_next = p2_prod[POW_W+31:32];
            end
            MARK_FRESH_RUN:
            begin
                gen_next = !gen_reg;
                p1_next  = {1'b0, cfg.first_decay};
                p2_next  = {1'b0, cfg.second_decay};
            end
            default:
            begin
                p1_next = p1_reg;
            end
        endcase
        push_job.index    = item_in.element_index;
        push_job.grad     = item_in.gradient_value;
        push_job.value    = item_in.current_value;
        push_job.d1       = (33'd1 << 32) - p1_next;
        push_job.d2       = (33'd1 << 32) - p2_next;
        push_job.gen      = gen_next;
        push_job.in_range = ({22'd0, item_in.element_index} < NUM_PARAMS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg  <= 33'd1 << 32;
            p2_reg  <= 33'd1 << 32;
            gen_reg <= 1'b0;
        end
        else if (push)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            gen_reg <= gen_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/adm_queue.sv =====
// two-entry job queue between front and back end
`default_nettype none
module adm_queue
    import adm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      full,
    output logic      nonempty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign pop_job  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/adm_back.sv =====
// back end: moment store, moment update, divide, root and step sequencer
`default_nettype none
module adm_back
    import adm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_nonempty,
    input  wire job_t  q_job,
    output logic       pop,
    output logic       clear_done,
    adm_out_if.source  item_out
);

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_READ  = 13'b0000000000100,
        ST_MUL   = 13'b0000000001000,
        ST_MIX   = 13'b0000000010000,
        ST_VDIF  = 13'b0000000100000,
        ST_VMUL  = 13'b0000001000000,
        ST_VSUM  = 13'b0000010000000,
        ST_DIV   = 13'b0000100000000,
        ST_SQRT  = 13'b0001000000000,
        ST_DEN0  = 13'b0010000000000,
        ST_DEN1  = 13'b0100000000000,
        ST_RES   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_W-1:0]  mem [NUM_PARAMS];
    logic [ROW_W-1:0]  rd_row_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] clr_cnt_reg;

    job_t              job_reg;
    logic signed [65:0] mprod_reg;
    logic [63:0]       gprod_reg;
    logic [VSQ_W-1:0]  v_old_reg;
    logic signed [31:0] m_new_reg;
    logic [VSQ_W-1:0]  gsq_reg;
    logic signed [VSQ_W:0] vdiff_reg;
    logic [63:0]       vlo_reg;
    logic signed [41:0] vhi_reg;
    logic [X_W-1:0]    num_sh_reg;
    logic [X_W-1:0]    quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  div_reg;
    logic [R_W-1:0]    root_reg;
    logic [R_W+1:0]    srem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              phase_reg;
    logic [R_W:0]      dsum_reg;
    logic [64:0]       den_lo_reg;
    logic [63:0]       numprod_reg;
    logic [33:0]       step_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic signed [31:0] out_value_reg;

    // combinational helpers
    logic              live;
    logic signed [31:0] m_old;
    logic signed [32:0] mdiff;
    logic [31:0]       gmag;
    logic signed [65:0] macc;
    logic [65:0]       mmag_w, mrnd_w;
    logic signed [31:0] m_mix;
    logic [64:0]       gsum;
    logic [64:0]       gsh;
    logic [VSQ_W-1:0]  gsq;
    logic signed [73:0] vacc;
    logic [VSQ_W-1:0]  v_new;
    logic              skip;
    logic [DEN_W:0]    drem_sh;
    logic              dge;
    logic [X_W-1:0]    q_next;
    logic [R_W+3:0]    srem_sh;
    logic [R_W+1:0]    strial;
    logic              sge;
    logic [R_W-1:0]    root_next;
    logic [DEN_W-1:0]  den;
    logic [31:0]       mmag;
    logic [Q_W-1:0]    num2;
    logic signed [34:0] np;
    logic              out_free;

    assign clear_done     = (state_reg != ST_CLEAR);
    assign item_out.valid = out_valid_reg;
    assign item_out.updated_index = out_index_reg;
    assign item_out.updated_value = out_value_reg;
    assign out_free = !out_valid_reg || item_out.ready;
    assign pop      = (state_reg == ST_IDLE) && q_nonempty;

    always_comb
    begin
        live   = job_reg.in_range && (rd_row_reg[ROW_W-1] == job_reg.gen);
        m_old  = live ? $signed(rd_row_reg[DATA_W-1:0]) : 32'sd0;
        mdiff  = $signed({m_old[31], m_old}) - $signed({job_reg.grad[31], job_reg.grad});
        gmag   = job_reg.grad[31] ? (32'd0 - job_reg.grad) : job_reg.grad;

        // first moment, rounded half away from zero
        macc   = mprod_reg + $signed({{2{job_reg.grad[31]}}, job_reg.grad, 32'd0});
        mmag_w = macc[65] ? (66'd0 - macc) : macc;
        mrnd_w = (mmag_w + 66'h8000_0000) >> 32;
        if (macc[65])
        begin
            m_mix = 32'd0 - mrnd_w[31:0];
        end
        else if (mrnd_w[33:0] > 34'h7FFF_FFFF)
        begin
            m_mix = 32'sh7FFF_FFFF;
        end
        else
        begin
            m_mix = mrnd_w[31:0];
        end

        gsum = {1'b0, gprod_reg} + (65'd1 << (FRAC_BITS - 1));
        gsh  = gsum >> FRAC_BITS;
        gsq  = (|gsh[64:VSQ_W]) ? {VSQ_W{1'b1}} : gsh[VSQ_W-1:0];

        vacc = $signed({10'd0, vlo_reg}) + $signed({vhi_reg, 32'd0})
             + $signed({2'b00, gsq_reg, 32'd0}) + 74'sh8000_0000;
        v_new = vacc[VSQ_W+31:32];
        skip  = !job_reg.in_range || (job_reg.d1 == '0) || (job_reg.d2 == '0)
             || (m_new_reg == 32'sd0);

        // one restoring divide step
        drem_sh = {rem_reg, num_sh_reg[X_W-1]};
        dge     = (drem_sh >= {1'b0, div_reg});
        q_next  = {quo_reg[X_W-2:0], dge};

        // one root digit
        srem_sh   = {srem_reg, num_sh_reg[X_W-1:X_W-2]};
        strial    = {root_reg, 2'b01};
        sge       = (srem_sh >= {2'b00, strial});
        root_next = {root_reg[R_W-2:0], sge};

        den  = DEN_W'(den_lo_reg)
             + (DEN_W'(job_reg.d1 * dsum_reg[R_W:32]) << 32);
        mmag = m_new_reg[31] ? (32'd0 - m_new_reg) : m_new_reg;
        num2 = {numprod_reg, 32'd0} + Q_W'(den >> 1);

        np = m_new_reg[31]
           ? $signed({{3{job_reg.value[31]}}, job_reg.value}) + $signed({1'b0, step_reg})
           : $signed({{3{job_reg.value[31]}}, job_reg.value}) - $signed({1'b0, step_reg});

        mem_we    = 1'b0;
        mem_addr  = job_reg.index[ADDR_W-1:0];
        mem_wdata = {job_reg.gen, v_new, m_new_reg};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_VSUM)
        begin
            mem_we = job_reg.in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_row_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == ADDR_W'(NUM_PARAMS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (q_nonempty) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_MIX;
            ST_MIX:   state_next = ST_VDIF;
            ST_VDIF:  state_next = ST_VMUL;
            ST_VMUL:  state_next = ST_VSUM;
            ST_VSUM:  state_next = skip ? ST_RES : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = phase_reg ? ST_RES : ST_SQRT;
                end
            end
            ST_SQRT:  if (cnt_reg == CNT_W'(1)) state_next = ST_DEN0;
            ST_DEN0:  state_next = ST_DEN1;
            ST_DEN1:  state_next = (den == '0) ? ST_RES : ST_DIV;
            ST_RES:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == ST_RES && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (item_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg <= q_job;
            end
            ST_MUL:
            begin
                mprod_reg <= $signed({1'b0, cfg.first_decay}) * mdiff;
                gprod_reg <= gmag * gmag;
                v_old_reg <= live ? rd_row_reg[DATA_W+VSQ_W-1:DATA_W] : '0;
            end
            ST_MIX:
            begin
                m_new_reg <= m_mix;
                gsq_reg   <= gsq;
            end
            ST_VDIF:
            begin
                vdiff_reg <= $signed({1'b0, v_old_reg}) - $signed({1'b0, gsq_reg});
            end
            ST_VMUL:
            begin
                vlo_reg <= cfg.second_decay * vdiff_reg[31:0];
                vhi_reg <= $signed({1'b0, cfg.second_decay}) * $signed(vdiff_reg[VSQ_W:32]);
            end
            ST_VSUM:
            begin
                step_reg   <= '0;
                num_sh_reg <= {v_new, {(X_W - VSQ_W){1'b0}}};
                div_reg    <= DEN_W'(job_reg.d2);
                rem_reg    <= '0;
                quo_reg    <= '0;
                cnt_reg    <= CNT_W'(X_W);
                phase_reg  <= 1'b0;
            end
            ST_DIV:
            begin
                rem_reg    <= dge ? DEN_W'(drem_sh - {1'b0, div_reg}) : drem_sh[DEN_W-1:0];
                quo_reg    <= q_next;
                if (cnt_reg == CNT_W'(1))
                begin
                    // quotient becomes the root operand, or the step
                    num_sh_reg <= q_next;
                    root_reg   <= '0;
                    srem_reg   <= '0;
                    cnt_reg    <= CNT_W'(R_W);
                    if (q_next[Q_W-1:0] > 96'd8589934592)
                    begin
                        step_reg <= 34'd1 << 33;
                    end
                    else
                    begin
                        step_reg <= q_next[33:0];
                    end
                end
                else
                begin
                    num_sh_reg <= num_sh_reg << 1;
                    cnt_reg    <= cnt_reg - CNT_W'(1);
                end
            end
            ST_SQRT:
            begin
                srem_reg   <= sge ? (R_W+2)'(srem_sh - {2'b00, strial}) : srem_sh[R_W+1:0];
                root_reg   <= root_next;
                num_sh_reg <= num_sh_reg << 2;
                cnt_reg    <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    dsum_reg <= {1'b0, root_next} + (R_W+1)'(cfg.stability_term);
                end
            end
            ST_DEN0:
            begin
                den_lo_reg  <= job_reg.d1 * dsum_reg[31:0];
                numprod_reg <= cfg.learning_rate * mmag;
            end
            ST_DEN1:
            begin
                step_reg   <= '0;
                num_sh_reg <= {num2, {(X_W - Q_W){1'b0}}};
                div_reg    <= den;
                rem_reg    <= '0;
                quo_reg    <= '0;
                cnt_reg    <= CNT_W'(Q_W);
                phase_reg  <= 1'b1;
            end
            ST_RES:
            begin
                // hold the waiting result until it is taken
                if (out_free)
                begin
                    out_index_reg <= job_reg.index;
                    if (np > 35'sh0_7FFF_FFFF)
                    begin
                        out_value_reg <= 32'sh7FFF_FFFF;
                    end
                    else if (np < -35'sh0_8000_0000)
                    begin
                        out_value_reg <= 32'sh8000_0000;
                    end
                    else
                    begin
                        out_value_reg <= np[31:0];
                    end
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/adam_parameter_update.sv =====
// top level of the adam parameter update block
//
//  channel    role    handshake      payload
//  item_in    sink    valid/ready    element_index, gradient_value, current_value, pass_mark
//  item_out   source  valid/ready    updated_index, updated_value
//  cfg        write   cfg_wr_en      cfg_index, cfg_wdata
//
// an item runs a 112-step divide for the root operand, a 56-step
// square root and a 96-step divide for the step, one bit or digit a cycle
// items skipping the update (no iteration yet, index out of range, zero moment) go straight to the result
// after reset a clearing pass zeroes the moment store; no item is taken
// the two-entry queue lets the front accept while the back end works or the
// output waits
`default_nettype none
module adam_parameter_update
    import adm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    adm_in_if.sink           item_in,
    adm_out_if.source        item_out,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic clear_done, q_full, q_nonempty, push, pop;
    job_t push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate  <= RST_LEARNING_RATE;
            cfg_reg.first_decay    <= RST_FIRST_DECAY;
            cfg_reg.second_decay   <= RST_SECOND_DECAY;
            cfg_reg.stability_term <= RST_STABILITY_TERM;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:  cfg_reg.learning_rate  <= cfg_wdata;
                CFG_FIRST_DECAY:    cfg_reg.first_decay    <= cfg_wdata;
                CFG_SECOND_DECAY:   cfg_reg.second_decay   <= cfg_wdata;
                CFG_STABILITY_TERM: cfg_reg.stability_term <= cfg_wdata;
                default:            cfg_reg.learning_rate  <= cfg_reg.learning_rate;
            endcase
        end
    end

    adm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .cfg        (cfg_reg),
        .clear_done (clear_done),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    adm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    adm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_nonempty (q_nonempty),
        .q_job      (pop_job),
        .pop        (pop),
        .clear_done (clear_done),
        .item_out   (item_out)
    );

endmodule
`default_nettype wire
